// ===== src/gfs_pkg.sv =====
// Package: shared constants, types and the CORDIC arctangent table.
package gfs_pkg;

  localparam int FENCE_SLOTS_DEF = 256;
  localparam int CORDIC_STEPS = 30;
  localparam logic [24:0] NEAREST_CAP_M = 25'd20000000;
  localparam logic [22:0] EARTH_RADIUS_M = 23'd6372795;
  localparam logic signed [36:0] RAD_PER_UDEG_Q61 = 37'sd40244552545;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [30:0] QUARTER_TURN = 31'sd90000000;
  localparam logic signed [30:0] HALF_TURN = 31'sd180000000;
  localparam logic signed [30:0] FULL_TURN = 31'sd360000000;

  typedef enum logic [1:0] {
    KIND_OUTSIDE  = 2'd0,
    KIND_INSIDE   = 2'd1,
    KIND_DISABLED = 2'd2,
    KIND_WRITE    = 2'd3
  } kind_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOCATE = 1'b1
  } action_t;

  // Request carried through the front/back queue.
  typedef struct packed {
    logic              locate;
    logic              enable;
    logic signed [27:0] lat;
    logic signed [28:0] lng;
  } job_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_RD, ST_RDW, ST_CHK,
    ST_TRIG, ST_TRIGW, ST_M1, ST_M2, ST_M3, ST_M4,
    ST_SQ, ST_SQW, ST_ATN, ST_ATNW, ST_DIST, ST_UPD, ST_DONE
  } bst_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314857;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;
      5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;
      5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;
      5'd9: atan_q30 = 34'sd2097149;
      default: atan_q30 = 34'sd1 <<< (5'd30 - i);
    endcase
  endfunction

endpackage

// ===== src/gfs_if.sv =====
// Interfaces: request, result and configuration channels.
interface gfs_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         slot;
  logic [7:0]         fence_type;
  logic [31:0]        radius_m;
  logic signed [27:0] latitude;
  logic signed [28:0] longitude;
  logic               enable;
  modport source (output valid, action, slot, fence_type, radius_m, latitude, longitude,
                  enable, input ready);
  modport sink (input valid, action, slot, fence_type, radius_m, latitude, longitude,
                enable, output ready);
endinterface

interface gfs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  hit_slot;
  logic [7:0]  hit_type;
  logic [24:0] hit_distance_m;
  logic [24:0] nearest_distance_m;
  modport source (output valid, result_kind, hit_slot, hit_type, hit_distance_m,
                  nearest_distance_m, input ready);
  modport sink (input valid, result_kind, hit_slot, hit_type, hit_distance_m,
                nearest_distance_m, output ready);
endinterface

interface gfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/gfs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module gfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/gfs_sincos.sv =====
// Sequential CORDIC sine/cosine of a microdegree angle, Q30 outputs.
module gfs_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [30:0] angle,
  output logic               done,
  output logic signed [33:0] sin_q,
  output logic signed [33:0] cos_q
);
  localparam logic signed [30:0] FULL_TURN_L = gfs_pkg::FULL_TURN;
  localparam logic signed [30:0] HALF_TURN_L = gfs_pkg::HALF_TURN;
  localparam logic signed [30:0] QUARTER_TURN_L = gfs_pkg::QUARTER_TURN;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic busy_r, busy_nxt, flip_r, flip_nxt, done_r, done_nxt;
  logic signed [30:0] r0, r1;
  logic signed [66:0] zprod;
  logic flip0;

  // Angle stays within one and a half turns, so one add or subtract of a full
  // turn brings it into [-180, 180) degrees.
  always_comb begin
    r0 = angle;
    if (r0 >= HALF_TURN_L) r0 = r0 - FULL_TURN_L;
    if (r0 < -HALF_TURN_L) r0 = r0 + FULL_TURN_L;
    flip0 = 1'b0;
    r1 = r0;
    if (r0 > QUARTER_TURN_L) begin
      r1 = r0 - HALF_TURN_L;
      flip0 = 1'b1;
    end else if (r0 < -QUARTER_TURN_L) begin
      r1 = r0 + HALF_TURN_L;
      flip0 = 1'b1;
    end
    zprod = 67'(r1) * 67'(gfs_pkg::RAD_PER_UDEG_Q61);
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt = gfs_pkg::CORDIC_GAIN_Q30;
      y_nxt = '0;
      z_nxt = 34'(zprod >>> 31);
      i_nxt = '0;
      busy_nxt = 1'b1;
      flip_nxt = flip0;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - gfs_pkg::atan_q30(i_r);
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + gfs_pkg::atan_q30(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(gfs_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    flip_r <= flip_nxt;
  end

  assign done = done_r;
  assign sin_q = flip_r ? -y_r : y_r;
  assign cos_q = flip_r ? -x_r : x_r;
endmodule

// ===== src/gfs_front.sv =====
// Front end: accepts requests, performs slot writes, queues jobs for the back end.
module gfs_front #(
  parameter int FENCE_SLOTS = gfs_pkg::FENCE_SLOTS_DEF,
  localparam int AW = (FENCE_SLOTS > 1) ? $clog2(FENCE_SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  gfs_req_if.sink        req,
  input  logic [7:0]     empty_code,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [7:0]     wr_type,
  output logic [31:0]    wr_radius,
  output logic [27:0]    wr_lat,
  output logic [28:0]    wr_lng,
  output logic           job_valid,
  output gfs_pkg::job_t  job,
  input  logic           job_pop
);
  // Two-entry queue.
  gfs_pkg::job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt, wp_r, wp_nxt;
  logic push, clr, in_range;

  // A write waits for an empty queue so the table never changes under a scan.
  assign req.ready = (cnt_r == 2'd0) ||
                     ((cnt_r != 2'd2) && (req.action == gfs_pkg::ACT_LOCATE));
  assign push = req.valid && req.ready;
  assign in_range = ({3'b0, req.slot} < 11'(FENCE_SLOTS));
  assign clr = (req.fence_type == empty_code);

  assign wr_en = push && (req.action == gfs_pkg::ACT_WRITE) && in_range;
  assign wr_addr = AW'(req.slot);
  assign wr_type = req.fence_type;
  assign wr_radius = clr ? '0 : req.radius_m;
  assign wr_lat = clr ? '0 : req.latitude;
  assign wr_lng = clr ? '0 : req.longitude;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_pop};
    rd_nxt = rd_r ^ job_pop;
    wp_nxt = wp_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wp_r <= wp_nxt;
    end
    if (push) begin
      q_r[wp_r] <= '{locate: req.action == gfs_pkg::ACT_LOCATE, enable: req.enable,
                     lat: req.latitude, lng: req.longitude};
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];
endmodule

// ===== src/gfs_back.sv =====
// Back end: scans the fence table, computes distances, holds the result register.
module gfs_back #(
  parameter int FENCE_SLOTS = gfs_pkg::FENCE_SLOTS_DEF,
  localparam int AW = (FENCE_SLOTS > 1) ? $clog2(FENCE_SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  gfs_pkg::job_t  job,
  output logic           job_pop,
  input  logic [7:0]     empty_code,
  output logic [AW-1:0]  rd_addr,
  input  logic [7:0]     rd_type,
  input  logic [31:0]    rd_radius,
  input  logic [27:0]    rd_lat,
  input  logic [28:0]    rd_lng,
  gfs_res_if.source      res
);
  gfs_pkg::bst_t st_r, st_nxt;
  logic [AW:0] idx_r, idx_nxt;
  logic [1:0] tsel_r, tsel_nxt;
  logic signed [33:0] sl_r, cl_r, s1_r, c1_r, s2_r, c2_r;
  logic signed [33:0] a_r, b_r, c_r, d_r;
  logic signed [67:0] p1, p2;
  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic signed [33:0] ax_r, ay_r, az_r;
  logic [4:0] ai_r;
  logic [24:0] dist_r, near_r, best_r;
  logic [7:0] bslot_r, btype_r;
  logic found_r;
  logic [56:0] dprod;
  logic trig_go, trig_done;
  logic signed [30:0] trig_ang;
  logic signed [33:0] trig_s, trig_c;
  logic out_v_r;
  logic [1:0] kind_r;
  logic signed [28:0] rd_lng_s;
  logic signed [27:0] rd_lat_s;

  assign rd_addr = idx_r[AW-1:0];
  assign rd_lng_s = rd_lng;
  assign rd_lat_s = rd_lat;

  always_comb begin
    case (tsel_r)
      2'd0: trig_ang = 31'(job.lng) - 31'(rd_lng_s);
      2'd1: trig_ang = 31'(job.lat);
      default: trig_ang = 31'(rd_lat_s);
    endcase
  end

  gfs_sincos u_trig (.clk, .rst_n, .start(trig_go), .angle(trig_ang), .done(trig_done),
                     .sin_q(trig_s), .cos_q(trig_c));

  assign p1 = 68'(a_r) * 68'(b_r);
  assign p2 = 68'(c_r) * 68'(d_r);
  assign dprod = 57'(az_r[31:0]) * 57'(gfs_pkg::EARTH_RADIUS_M);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      gfs_pkg::ST_IDLE: if (job_valid && !out_v_r) st_nxt = gfs_pkg::ST_START;
      gfs_pkg::ST_START: st_nxt = (job.locate && job.enable) ? gfs_pkg::ST_RD
                                                              : gfs_pkg::ST_DONE;
      gfs_pkg::ST_RD: st_nxt = (idx_r == (AW+1)'(FENCE_SLOTS)) ? gfs_pkg::ST_DONE
                                                               : gfs_pkg::ST_RDW;
      gfs_pkg::ST_RDW: st_nxt = gfs_pkg::ST_CHK;
      gfs_pkg::ST_CHK: st_nxt = (rd_type == empty_code) ? gfs_pkg::ST_RD
                                                        : gfs_pkg::ST_TRIG;
      gfs_pkg::ST_TRIG: st_nxt = gfs_pkg::ST_TRIGW;
      gfs_pkg::ST_TRIGW: if (trig_done)
        st_nxt = (tsel_r == 2'd2) ? gfs_pkg::ST_M1 : gfs_pkg::ST_TRIG;
      gfs_pkg::ST_M1: st_nxt = gfs_pkg::ST_M2;
      gfs_pkg::ST_M2: st_nxt = gfs_pkg::ST_M3;
      gfs_pkg::ST_M3: st_nxt = gfs_pkg::ST_M4;
      gfs_pkg::ST_M4: st_nxt = gfs_pkg::ST_SQ;
      gfs_pkg::ST_SQ: st_nxt = gfs_pkg::ST_SQW;
      gfs_pkg::ST_SQW: if (sq_bit_r == 0) st_nxt = gfs_pkg::ST_ATN;
      gfs_pkg::ST_ATN: st_nxt = gfs_pkg::ST_ATNW;
      gfs_pkg::ST_ATNW: if (ai_r == 5'(gfs_pkg::CORDIC_STEPS)) st_nxt = gfs_pkg::ST_DIST;
      gfs_pkg::ST_DIST: st_nxt = gfs_pkg::ST_UPD;
      gfs_pkg::ST_UPD: st_nxt = gfs_pkg::ST_RD;
      gfs_pkg::ST_DONE: st_nxt = gfs_pkg::ST_IDLE;
      default: st_nxt = gfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    trig_go = (st_r == gfs_pkg::ST_TRIG);
    job_pop = (st_r == gfs_pkg::ST_DONE);
    idx_nxt = idx_r;
    tsel_nxt = tsel_r;
    if (st_r == gfs_pkg::ST_START) idx_nxt = '0;
    if (st_r == gfs_pkg::ST_RDW) tsel_nxt = 2'd0;
    if (st_r == gfs_pkg::ST_TRIGW && trig_done) tsel_nxt = tsel_r + 2'd1;
    if (st_r == gfs_pkg::ST_UPD ||
        (st_r == gfs_pkg::ST_CHK && rd_type == empty_code)) idx_nxt = idx_r + 1'b1;
  end

  // Intermediates held across the product steps.
  logic signed [33:0] t1_r, t2_r, xv_r, u_r, tt_r;
  logic [33:0] at, au;
  assign at = tt_r[33] ? 34'(-tt_r) : tt_r;
  assign au = u_r[33] ? 34'(-u_r) : u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gfs_pkg::ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == gfs_pkg::ST_DONE) out_v_r <= 1'b1;
      else if (res.ready) out_v_r <= 1'b0;
    end
    idx_r <= idx_nxt;
    tsel_r <= tsel_nxt;
    if (st_r == gfs_pkg::ST_TRIGW && trig_done) begin
      case (tsel_r)
        2'd0: begin sl_r <= trig_s; cl_r <= trig_c; end
        2'd1: begin s1_r <= trig_s; c1_r <= trig_c; end
        default: begin s2_r <= trig_s; c2_r <= trig_c; end
      endcase
    end
    case (st_r)
      gfs_pkg::ST_START: begin
        near_r <= gfs_pkg::NEAREST_CAP_M;
        found_r <= 1'b0;
        best_r <= '0;
        bslot_r <= '0;
        btype_r <= '0;
      end
      gfs_pkg::ST_M1: begin
        a_r <= s1_r; b_r <= c2_r; c_r <= c1_r; d_r <= c2_r;
      end
      gfs_pkg::ST_M2: begin
        t1_r <= 34'(p1 >>> 30);
        t2_r <= 34'(p2 >>> 30);
        a_r <= c1_r; b_r <= s2_r; c_r <= c2_r; d_r <= sl_r;
      end
      gfs_pkg::ST_M3: begin
        tt_r <= 34'(p1 >>> 30);
        u_r <= 34'(p2 >>> 30);
        a_r <= t1_r; b_r <= cl_r; c_r <= t2_r; d_r <= cl_r;
      end
      gfs_pkg::ST_M4: begin
        tt_r <= tt_r - 34'(p1 >>> 30);
        xv_r <= 34'(p2 >>> 30);
        a_r <= s1_r; b_r <= s2_r; c_r <= '0; d_r <= '0;
      end
      gfs_pkg::ST_SQ: begin
        xv_r <= xv_r + 34'(p1 >>> 30);
        sq_n_r <= 64'(at) * 64'(at) + 64'(au) * 64'(au);
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
      end
      gfs_pkg::ST_SQW: begin
        if (sq_bit_r != 0) begin
          if (sq_res_r == 0 && sq_bit_r > sq_n_r) begin
            sq_bit_r <= sq_bit_r >> 2;
          end else if (sq_n_r >= sq_res_r + sq_bit_r) begin
            sq_n_r <= sq_n_r - (sq_res_r + sq_bit_r);
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            sq_bit_r <= sq_bit_r >> 2;
          end else begin
            sq_res_r <= sq_res_r >> 1;
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
      end
      gfs_pkg::ST_ATN: begin
        if (sq_res_r == 0 && !xv_r[33]) begin
          ax_r <= 34'sd1; ay_r <= '0; az_r <= '0; ai_r <= 5'(gfs_pkg::CORDIC_STEPS);
        end else if (xv_r[33]) begin
          ax_r <= 34'(sq_res_r); ay_r <= -xv_r; az_r <= gfs_pkg::HALF_PI_Q30;
          ai_r <= '0;
        end else begin
          ax_r <= xv_r; ay_r <= 34'(sq_res_r); az_r <= '0;
          ai_r <= '0;
        end
      end
      gfs_pkg::ST_ATNW: begin
        if (ai_r != 5'(gfs_pkg::CORDIC_STEPS)) begin
          if (ay_r > 0) begin
            ax_r <= ax_r + (ay_r >>> ai_r);
            ay_r <= ay_r - (ax_r >>> ai_r);
            az_r <= az_r + gfs_pkg::atan_q30(ai_r);
          end else begin
            ax_r <= ax_r - (ay_r >>> ai_r);
            ay_r <= ay_r + (ax_r >>> ai_r);
            az_r <= az_r - gfs_pkg::atan_q30(ai_r);
          end
          ai_r <= ai_r + 5'd1;
        end
      end
      gfs_pkg::ST_DIST: begin
        dist_r <= az_r[33] ? '0 : dprod[54:30];
      end
      gfs_pkg::ST_UPD: begin
        if (dist_r < near_r) near_r <= dist_r;
        if ({7'b0, dist_r} < rd_radius && (!found_r || dist_r < best_r)) begin
          found_r <= 1'b1;
          best_r <= dist_r;
          bslot_r <= 8'(idx_r);
          btype_r <= rd_type;
        end
      end
      gfs_pkg::ST_DONE: begin
        if (!job.locate) kind_r <= gfs_pkg::KIND_WRITE;
        else if (!job.enable) kind_r <= gfs_pkg::KIND_DISABLED;
        else if (found_r) kind_r <= gfs_pkg::KIND_INSIDE;
        else kind_r <= gfs_pkg::KIND_OUTSIDE;
      end
      default: ;
    endcase
  end

  logic live;
  assign live = job.locate && job.enable;
  logic live_r;
  always_ff @(posedge clk) if (st_r == gfs_pkg::ST_DONE) live_r <= live;

  assign res.valid = out_v_r;
  assign res.result_kind = kind_r;
  assign res.hit_slot = (kind_r == gfs_pkg::KIND_INSIDE) ? bslot_r : '0;
  assign res.hit_type = (kind_r == gfs_pkg::KIND_INSIDE) ? btype_r : '0;
  assign res.hit_distance_m = (kind_r == gfs_pkg::KIND_INSIDE) ? best_r : '0;
  assign res.nearest_distance_m = live_r ? near_r : '0;
endmodule

// ===== src/geofence_nearest_containing_search.sv =====
// Top level: geofence table with nearest and containing-fence search.
//
//  channel | dir | payload
//  in_     | in  | action, slot, fence_type, radius_m, latitude, longitude, enable
//  out_    | out | result_kind, hit_slot, hit_type, hit_distance_m, nearest_distance_m
//  cfg_    | in  | data: empty type code
//
// A write or disabled request passes only the start and done states before its result is
// valid; a locate request scans all FENCE_SLOTS slots, and for each occupied slot runs
// three sin/cos CORDIC runs, 4 product steps, a bit-pair square root, an atan CORDIC
// and the distance and update steps.
// Reset is synchronous; the type store powers up through a clearing pass over all
// FENCE_SLOTS entries, during which no request is taken.
// The front queue holds two requests, so locates keep flowing while a result
// waits; a write waits until the queue has drained.
module geofence_nearest_containing_search #(
  parameter int FENCE_SLOTS = gfs_pkg::FENCE_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  gfs_req_if.sink   in_req,
  gfs_res_if.source out_res,
  gfs_cfg_if.sink   cfg
);
  localparam int AW = (FENCE_SLOTS > 1) ? $clog2(FENCE_SLOTS) : 1;

  logic [7:0] empty_r;
  logic [AW:0] clr_r;
  logic clearing;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= 8'd255;
      clr_r <= '0;
    end else begin
      if (cfg.valid) empty_r <= cfg.data;
      if (clearing) clr_r <= clr_r + 1'b1;
    end
  end
  assign clearing = (clr_r != (AW+1)'(FENCE_SLOTS));

  // Gate the request channel during the clearing pass.
  gfs_req_if gated ();
  assign gated.valid = in_req.valid && !clearing;
  assign in_req.ready = gated.ready && !clearing;
  assign gated.action = in_req.action;
  assign gated.slot = in_req.slot;
  assign gated.fence_type = in_req.fence_type;
  assign gated.radius_m = in_req.radius_m;
  assign gated.latitude = in_req.latitude;
  assign gated.longitude = in_req.longitude;
  assign gated.enable = in_req.enable;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0] wr_type, rd_type;
  logic [31:0] wr_radius, rd_radius;
  logic [27:0] wr_lat, rd_lat;
  logic [28:0] wr_lng, rd_lng;
  logic job_valid, job_pop;
  gfs_pkg::job_t job;

  gfs_front #(.FENCE_SLOTS(FENCE_SLOTS)) u_front (
    .clk, .rst_n, .req(gated.sink), .empty_code(empty_r),
    .wr_en, .wr_addr, .wr_type, .wr_radius, .wr_lat, .wr_lng,
    .job_valid, .job, .job_pop);

  // Type store takes the clearing pass writes (reset code 255).
  logic t_we;
  logic [AW-1:0] t_addr;
  logic [7:0] t_data;
  assign t_we = clearing || wr_en;
  assign t_addr = clearing ? clr_r[AW-1:0] : wr_addr;
  assign t_data = clearing ? 8'd255 : wr_type;

  gfs_ram #(.WIDTH(8), .DEPTH(FENCE_SLOTS)) u_type (
    .clk, .we(t_we), .waddr(t_addr), .wdata(t_data), .raddr(rd_addr), .rdata(rd_type));
  gfs_ram #(.WIDTH(32), .DEPTH(FENCE_SLOTS)) u_rad (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_radius), .raddr(rd_addr),
    .rdata(rd_radius));
  gfs_ram #(.WIDTH(28), .DEPTH(FENCE_SLOTS)) u_lat (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_lat), .raddr(rd_addr), .rdata(rd_lat));
  gfs_ram #(.WIDTH(29), .DEPTH(FENCE_SLOTS)) u_lng (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_lng), .raddr(rd_addr), .rdata(rd_lng));

  gfs_back #(.FENCE_SLOTS(FENCE_SLOTS)) u_back (
    .clk, .rst_n, .job_valid, .job, .job_pop, .empty_code(empty_r),
    .rd_addr, .rd_type, .rd_radius, .rd_lat, .rd_lng, .res(out_res));

`ifndef SYNTHESIS
  // No request is taken during the clearing pass.
  a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_req.ready) else $error("request during clear");
  // Inside results never report a nearest distance above the hit distance.
  a_hit_near: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.result_kind == gfs_pkg::KIND_INSIDE) |->
    (out_res.nearest_distance_m <= out_res.hit_distance_m))
    else $error("nearest exceeds hit");
  // A held result keeps its kind until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |=> $stable(out_res.result_kind))
    else $error("result changed while stalled");
`endif
endmodule
